[src/bmc_pkg.sv]
// Package with shared types, codes and constants of the button menu controller.
package bmc_pkg;

    // Key codes
    localparam logic [8:0] KEY_VOL_DOWN = 9'd114;
    localparam logic [8:0] KEY_VOL_UP   = 9'd115;
    localparam logic [8:0] KEY_PWR      = 9'd116;
    localparam logic [8:0] KEY_MENU     = 9'd139;
    localparam logic [8:0] KEY_BACK     = 9'd158;
    localparam logic [8:0] KEY_HOME     = 9'd352;

    // Key values
    localparam logic [1:0] KV_RELEASE = 2'd0;
    localparam logic [1:0] KV_PRESS   = 2'd1;

    // Sources
    localparam logic [1:0] SRC_BUTTONS = 2'd0;
    localparam logic [1:0] SRC_TOUCH   = 2'd1;

    // Item kinds
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Decoded events
    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_UP      = 4'd1;
    localparam logic [3:0] EV_DOWN    = 4'd2;
    localparam logic [3:0] EV_PSHORT  = 4'd3;
    localparam logic [3:0] EV_PREBOOT = 4'd4;
    localparam logic [3:0] EV_POFF    = 4'd5;
    localparam logic [3:0] EV_MENU    = 4'd6;
    localparam logic [3:0] EV_BACK    = 4'd7;
    localparam logic [3:0] EV_HOME    = 4'd8;

    // Modes
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MENU = 2'd1;
    localparam logic [1:0] M_BRI  = 2'd2;
    localparam logic [1:0] M_BAT  = 2'd3;

    // Commands
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_REBOOT   = 3'd1;
    localparam logic [2:0] CMD_POWEROFF = 3'd2;
    localparam logic [2:0] CMD_WIFI     = 3'd3;
    localparam logic [2:0] CMD_SSH      = 3'd4;
    localparam logic [2:0] CMD_KEYBOARD = 3'd5;

    // Menu sizes, highest index of each level
    localparam logic [2:0] ROOT_LAST = 3'd4;
    localparam logic [2:0] NET_LAST  = 3'd1;

    // Root menu entries
    localparam logic [2:0] ROOT_BATTERY  = 3'd0;
    localparam logic [2:0] ROOT_BRIGHT   = 3'd1;
    localparam logic [2:0] ROOT_NETWORK  = 3'd2;
    localparam logic [2:0] ROOT_KEYBOARD = 3'd3;
    localparam logic [2:0] ROOT_EXIT     = 3'd4;

    // Network submenu entries
    localparam logic [2:0] NET_WIFI = 3'd0;
    localparam logic [2:0] NET_SSH  = 3'd1;

    // Reset values
    localparam logic [2:0] HOLD_MAX        = 3'd7;
    localparam logic [4:0] LEVEL_RESET     = 5'd8;
    localparam logic [2:0] REBOOT_RESET    = 3'd2;
    localparam logic [2:0] POWEROFF_RESET  = 3'd5;
    localparam logic [4:0] BRIGHT_TOP_RESET = 5'd24;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_REBOOT   = 2'd0;
    localparam logic [1:0] REG_POWEROFF = 2'd1;
    localparam logic [1:0] REG_TOP      = 2'd2;

    typedef struct packed {
        logic [2:0] reboot_hold_ticks;
        logic [2:0] poweroff_hold_ticks;
        logic [4:0] brightness_top;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [1:0] source;
        logic       is_key_type;
        logic [8:0] key_code;
        logic [1:0] key_value;
    } t_item;

    typedef struct packed {
        logic       redraw;
        logic [2:0] command;
        logic       blank_write;
        logic       blanked;
        logic       level_write;
        logic [4:0] level;
        logic [2:0] highlighted;
        logic       menu_level;
        logic [1:0] mode;
    } t_result;

endpackage

[src/bmc_cfg.sv]
// Configuration registers behind the APB-style port.
module bmc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bmc_pkg::t_cfg     o_cfg
);

    bmc_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reboot_hold_ticks   <= bmc_pkg::REBOOT_RESET;
            r_cfg.poweroff_hold_ticks <= bmc_pkg::POWEROFF_RESET;
            r_cfg.brightness_top      <= bmc_pkg::BRIGHT_TOP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                bmc_pkg::REG_REBOOT:   r_cfg.reboot_hold_ticks   <= pwdata[2:0];
                bmc_pkg::REG_POWEROFF: r_cfg.poweroff_hold_ticks <= pwdata[2:0];
                bmc_pkg::REG_TOP:      r_cfg.brightness_top      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = 32'd0;
        case (reg_idx)
            bmc_pkg::REG_REBOOT:   prdata = {29'd0, r_cfg.reboot_hold_ticks};
            bmc_pkg::REG_POWEROFF: prdata = {29'd0, r_cfg.poweroff_hold_ticks};
            bmc_pkg::REG_TOP:      prdata = {27'd0, r_cfg.brightness_top};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[src/bmc_evdec.sv]
// Event decoder: power hold counter and key item to event classification.
module bmc_evdec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  bmc_pkg::t_item    i_item,
    input  bmc_pkg::t_cfg     i_cfg,
    output logic [3:0]        o_ev
);

    logic [2:0] r_hold;
    logic [2:0] n_hold;
    logic       btn_key;
    logic       touch_key;

    assign btn_key   = (i_item.kind == bmc_pkg::KIND_KEY) & i_item.is_key_type
                       & (i_item.source == bmc_pkg::SRC_BUTTONS);
    assign touch_key = (i_item.kind == bmc_pkg::KIND_KEY) & i_item.is_key_type
                       & (i_item.source == bmc_pkg::SRC_TOUCH)
                       & (i_item.key_value == bmc_pkg::KV_PRESS);

    // Hold counter: ticks count up to saturation, a power press restarts it
    always_comb begin
        n_hold = r_hold;
        if (i_item.kind == bmc_pkg::KIND_TICK) begin
            if (r_hold != bmc_pkg::HOLD_MAX) n_hold = r_hold + 3'd1;
        end else if (btn_key && i_item.key_code == bmc_pkg::KEY_PWR
                     && i_item.key_value == bmc_pkg::KV_PRESS) begin
            n_hold = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= bmc_pkg::HOLD_MAX;
        end else if (i_adv) begin
            r_hold <= n_hold;
        end
    end

    // Classification; power-off threshold takes priority over reboot
    always_comb begin
        o_ev = bmc_pkg::EV_NONE;
        if (btn_key) begin
            if (i_item.key_code == bmc_pkg::KEY_PWR) begin
                if (i_item.key_value == bmc_pkg::KV_RELEASE) begin
                    if (r_hold >= i_cfg.poweroff_hold_ticks)    o_ev = bmc_pkg::EV_POFF;
                    else if (r_hold >= i_cfg.reboot_hold_ticks) o_ev = bmc_pkg::EV_PREBOOT;
                    else                                        o_ev = bmc_pkg::EV_PSHORT;
                end
            end else if (i_item.key_value == bmc_pkg::KV_PRESS) begin
                if (i_item.key_code == bmc_pkg::KEY_VOL_UP)        o_ev = bmc_pkg::EV_UP;
                else if (i_item.key_code == bmc_pkg::KEY_VOL_DOWN) o_ev = bmc_pkg::EV_DOWN;
                else if (i_item.key_code == bmc_pkg::KEY_HOME)     o_ev = bmc_pkg::EV_HOME;
            end
        end else if (touch_key) begin
            if (i_item.key_code == bmc_pkg::KEY_MENU)      o_ev = bmc_pkg::EV_MENU;
            else if (i_item.key_code == bmc_pkg::KEY_BACK) o_ev = bmc_pkg::EV_BACK;
        end
    end

endmodule

[src/bmc_fsm.sv]
// Mode machine: menu navigation, brightness, blanking and command strobes.
module bmc_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [3:0]        i_ev,
    input  bmc_pkg::t_cfg     i_cfg,
    output bmc_pkg::t_result  o_res
);

    logic [1:0] r_mode;
    logic       r_menu_level;
    logic [2:0] r_hl;
    logic [4:0] r_level;
    logic       r_blank;

    logic [1:0] n_mode;
    logic       n_menu_level;
    logic [2:0] n_hl;
    logic [4:0] n_level;
    logic       n_blank;

    logic       lvl_wr;
    logic       blk_wr;
    logic [2:0] cmd;
    logic       redraw;
    logic       handled;
    logic [2:0] last_idx;
    logic [4:0] lvl_up;
    logic [4:0] lvl_dn;

    assign last_idx = r_menu_level ? bmc_pkg::NET_LAST : bmc_pkg::ROOT_LAST;

    // Clamped brightness steps
    assign lvl_up = (r_level >= i_cfg.brightness_top) ? i_cfg.brightness_top
                                                      : r_level + 5'd1;
    always_comb begin
        if (r_level == 5'd0)                           lvl_dn = 5'd0;
        else if (r_level - 5'd1 > i_cfg.brightness_top) lvl_dn = i_cfg.brightness_top;
        else                                            lvl_dn = r_level - 5'd1;
    end

    // Per-mode rules first, then the rules shared by every mode for unhandled events
    always_comb begin
        n_mode       = r_mode;
        n_menu_level = r_menu_level;
        n_hl         = r_hl;
        n_level      = r_level;
        n_blank      = r_blank;
        lvl_wr       = 1'b0;
        blk_wr       = 1'b0;
        cmd          = bmc_pkg::CMD_NONE;
        redraw       = 1'b0;
        handled      = 1'b0;

        case (r_mode)
            bmc_pkg::M_BRI: begin
                if (i_ev == bmc_pkg::EV_UP) begin
                    n_level = lvl_up; lvl_wr = 1'b1; redraw = 1'b1; handled = 1'b1;
                end else if (i_ev == bmc_pkg::EV_DOWN) begin
                    n_level = lvl_dn; lvl_wr = 1'b1; redraw = 1'b1; handled = 1'b1;
                end else if (i_ev == bmc_pkg::EV_PSHORT || i_ev == bmc_pkg::EV_BACK) begin
                    n_mode = bmc_pkg::M_MENU; redraw = 1'b1; handled = 1'b1;
                end
            end
            bmc_pkg::M_BAT: begin
                if (i_ev == bmc_pkg::EV_PSHORT || i_ev == bmc_pkg::EV_UP
                    || i_ev == bmc_pkg::EV_DOWN || i_ev == bmc_pkg::EV_BACK
                    || i_ev == bmc_pkg::EV_MENU) begin
                    n_mode = bmc_pkg::M_MENU; redraw = 1'b1; handled = 1'b1;
                end
            end
            bmc_pkg::M_MENU: begin
                if (i_ev == bmc_pkg::EV_UP) begin
                    n_hl = (r_hl != 3'd0) ? r_hl - 3'd1 : last_idx;
                    redraw = 1'b1; handled = 1'b1;
                end else if (i_ev == bmc_pkg::EV_DOWN) begin
                    n_hl = (r_hl < last_idx) ? r_hl + 3'd1 : 3'd0;
                    redraw = 1'b1; handled = 1'b1;
                end else if (i_ev == bmc_pkg::EV_PSHORT) begin
                    redraw = 1'b1; handled = 1'b1;
                    if (!r_menu_level) begin
                        case (r_hl)
                            bmc_pkg::ROOT_BATTERY:  n_mode = bmc_pkg::M_BAT;
                            bmc_pkg::ROOT_BRIGHT:   n_mode = bmc_pkg::M_BRI;
                            bmc_pkg::ROOT_NETWORK: begin
                                n_menu_level = 1'b1; n_hl = 3'd0;
                            end
                            bmc_pkg::ROOT_KEYBOARD: cmd = bmc_pkg::CMD_KEYBOARD;
                            bmc_pkg::ROOT_EXIT: begin
                                n_menu_level = 1'b0; n_hl = 3'd0; n_mode = bmc_pkg::M_IDLE;
                            end
                            default: ;
                        endcase
                    end else begin
                        case (r_hl)
                            bmc_pkg::NET_WIFI: cmd = bmc_pkg::CMD_WIFI;
                            bmc_pkg::NET_SSH:  cmd = bmc_pkg::CMD_SSH;
                            default: ;
                        endcase
                    end
                end else if (i_ev == bmc_pkg::EV_BACK) begin
                    // back leaves the submenu, or the menu from the root
                    n_menu_level = 1'b0; n_hl = 3'd0;
                    if (!r_menu_level) n_mode = bmc_pkg::M_IDLE;
                    redraw = 1'b1; handled = 1'b1;
                end else if (i_ev == bmc_pkg::EV_MENU) begin
                    n_menu_level = 1'b0; n_hl = 3'd0; n_mode = bmc_pkg::M_IDLE;
                    redraw = 1'b1; handled = 1'b1;
                end
            end
            default: begin
                if (i_ev == bmc_pkg::EV_PSHORT) begin
                    n_blank = ~r_blank; blk_wr = 1'b1; handled = 1'b1;
                end
            end
        endcase

        if (!handled) begin
            if (i_ev == bmc_pkg::EV_MENU) begin
                n_blank = 1'b0; blk_wr = 1'b1;
                n_menu_level = 1'b0; n_hl = 3'd0; n_mode = bmc_pkg::M_MENU;
                redraw = 1'b1;
            end else if (i_ev == bmc_pkg::EV_HOME) begin
                cmd = bmc_pkg::CMD_KEYBOARD;
            end else if (i_ev == bmc_pkg::EV_PREBOOT) begin
                cmd = bmc_pkg::CMD_REBOOT;
            end else if (i_ev == bmc_pkg::EV_POFF) begin
                cmd = bmc_pkg::CMD_POWEROFF;
            end
        end
    end

    // State update as the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= bmc_pkg::M_IDLE;
            r_menu_level <= 1'b0;
            r_hl         <= 3'd0;
            r_level      <= bmc_pkg::LEVEL_RESET;
            r_blank      <= 1'b0;
        end else if (i_adv) begin
            r_mode       <= n_mode;
            r_menu_level <= n_menu_level;
            r_hl         <= n_hl;
            r_level      <= n_level;
            r_blank      <= n_blank;
        end
    end

    // Result carries the state after the item
    always_comb begin
        o_res.mode        = n_mode;
        o_res.menu_level  = n_menu_level;
        o_res.highlighted = n_hl;
        o_res.level       = n_level;
        o_res.level_write = lvl_wr;
        o_res.blanked     = n_blank;
        o_res.blank_write = blk_wr;
        o_res.command     = cmd;
        o_res.redraw      = redraw;
    end

endmodule

[src/button_menu_controller.sv]
// Top level of the button menu controller: input and result registers around the logic.
// Usage:
//   Items enter on the s_axis channel. s_axis_tuser is the kind (0 key event,
//   1 one-second tick); s_axis_tdata carries source, key type flag, key code
//   and key value. Every item gives exactly one result on m_axis: the mode,
//   menu level, highlight, brightness level and blank state after the item,
//   plus one-item strobes for level and blank writes, a command code and redraw.
//   An accepted item passes through the input register and then the result
//   register before it is presented on m_axis.
//   Throughput: one item per cycle while the receiver does not stall; the input
//   register decode and mode update is a single short combinational step, so
//   items may follow back to back. When the receiver stalls, the result
//   register holds its item, the input register still takes one more item,
//   and s_axis_tready drops only when both registers are full.
//   The APB-style port holds the reboot and power-off hold thresholds and the top
//   brightness level; the user writes it only while the block is idle (not enforced).
//   Reset (synchronous, active low) clears both registers, returns to idle
//   at root menu, brightness 8, not blanked, with the hold counter saturated.
module button_menu_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // source[1:0], is_key_type[2], key_code[11:3],
                                       // key_value[13:12], zero[15:14]
    input  logic        s_axis_tuser,  // kind[0]
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // mode[1:0], menu_level[2], highlighted[5:3],
                                       // level[10:6], level_write[11], blanked[12],
                                       // blank_write[13], command[16:14], redraw[17],
                                       // zero[23:18]
);

    bmc_pkg::t_cfg    cfg;
    bmc_pkg::t_item   r_item;
    bmc_pkg::t_result res;
    bmc_pkg::t_result r_res;
    logic             r_in_vld;
    logic             r_out_vld;
    logic             adv;
    logic [3:0]       ev;

    // Item moves to the result register when that register is free or drains
    assign adv           = r_in_vld & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_in_vld | adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.kind        <= s_axis_tuser;
            r_item.source      <= s_axis_tdata[1:0];
            r_item.is_key_type <= s_axis_tdata[2];
            r_item.key_code    <= s_axis_tdata[11:3];
            r_item.key_value   <= s_axis_tdata[13:12];
        end
    end

    bmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bmc_evdec u_evdec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_ev    (ev)
    );

    bmc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ev    (ev),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_res};

`ifndef SYNTH
    // The networking submenu exists only inside the menu mode
    a_submenu_in_menu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res.menu_level) |-> (r_res.mode == bmc_pkg::M_MENU))
        else $error("submenu level outside menu mode");

    // Highlight stays within the current menu
    a_highlight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_res.menu_level ? (r_res.highlighted <= bmc_pkg::NET_LAST)
                                            : (r_res.highlighted <= bmc_pkg::ROOT_LAST)))
        else $error("highlight outside menu");

    // A command never comes with a level or blank write
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res.command != bmc_pkg::CMD_NONE)
            |-> (!r_res.level_write && !r_res.blank_write))
        else $error("command together with a write strobe");

    // A stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_res)))
        else $error("stalled result lost");
`endif

endmodule
